// File: sv/pcrl_pkg.sv
// ----------------------------------------------------------------------------
// pcrl_pkg: shared types and constants for the colour ramp lookup
// Holds opcodes, field widths and the cell-to-cell scan record.
// ----------------------------------------------------------------------------
package pcrl_pkg;
    localparam logic OP_QUERY = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_COUNT = 2'd1;

    localparam int PosW = 16;
    localparam int ColW = 32;

    // Running neighbour search carried from cell to cell.
    typedef struct packed {
        logic            have_lo;
        logic [PosW-1:0] lo;
        logic [ColW-1:0] lo_col;
        logic            have_hi;
        logic [PosW-1:0] hi;
        logic [ColW-1:0] hi_col;
    } t_scan;

    // Reset contents of the control table.
    function automatic logic [PosW+ColW-1:0] reset_entry(input int i);
        case (i)
            0: reset_entry = {16'd0,     32'h000000FF};
            1: reset_entry = {16'd65535, 32'hFF0000FF};
            2: reset_entry = {16'd0,     32'h0000FFFF};
            3: reset_entry = {16'd16384, 32'h00FFFFFF};
            4: reset_entry = {16'd32768, 32'h00FF00FF};
            5: reset_entry = {16'd49151, 32'hFFFF00FF};
            6: reset_entry = {16'd65535, 32'hFF0000FF};
            default: reset_entry = '0;
        endcase
    endfunction
endpackage

// File: sv/pcrl_cell.sv
// ----------------------------------------------------------------------------
// pcrl_cell: one control point of the ramp
// Stores one entry and, on a scan step, folds it into the passing record.
// ----------------------------------------------------------------------------
module pcrl_cell
    import pcrl_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_we,
    input  logic [PosW-1:0] i_wpos,
    input  logic [ColW-1:0] i_wcol,
    input  logic            i_step,
    input  logic            i_active,
    input  logic [PosW-1:0] i_v,
    input  t_scan           i_scan,
    output t_scan           o_scan
);
    logic [PosW-1:0] r_pos;
    logic [ColW-1:0] r_col;
    t_scan           r_scan;
    t_scan           n_scan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            {r_pos, r_col} <= reset_entry(IDX);
        end else if (i_we) begin
            r_pos <= i_wpos;
            r_col <= i_wcol;
        end
    end

    always_comb begin
        n_scan = i_scan;
        if (i_active) begin
            if (r_pos <= i_v) begin
                if (!i_scan.have_lo || r_pos >= i_scan.lo) begin
                    n_scan.have_lo = 1'b1;
                    n_scan.lo      = r_pos;
                    n_scan.lo_col  = r_col;
                end
            end else if (!i_scan.have_hi || r_pos <= i_scan.hi) begin
                n_scan.have_hi = 1'b1;
                n_scan.hi      = r_pos;
                n_scan.hi_col  = r_col;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) r_scan <= n_scan;
    end
    assign o_scan = r_scan;
endmodule

// File: sv/pcrl_blend.sv
// ----------------------------------------------------------------------------
// pcrl_blend: serial interpolation of four colour channels
// One restoring division per channel, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcrl_blend
    import pcrl_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  t_scan           i_scan,
    input  logic [PosW-1:0] i_v,
    output logic            o_done,
    output logic [ColW-1:0] o_color
);
    // Numerator is at most 255*65535 plus half the divisor, which fits in 24 bits; 25 are kept.
    localparam int NumW = 25;

    logic            r_busy;
    logic [1:0]      r_ch;
    logic [4:0]      r_bit;
    logic [NumW-1:0] r_num;
    logic [PosW:0]   r_rem;
    logic [NumW-1:0] r_quo;
    logic [PosW-1:0] r_d;
    logic [PosW-1:0] r_wlo;
    logic [PosW-1:0] r_whi;
    logic [ColW-1:0] r_clo;
    logic [ColW-1:0] r_chi;
    logic [ColW-1:0] r_out;
    logic            r_done;
    logic [1:0]      r_phase;   // 0 multiply lo, 1 multiply hi, 2 divide, 3 store

    logic [7:0]      w_a;
    logic [7:0]      w_b;
    logic [23:0]     w_pa;
    logic [23:0]     w_pb;
    logic [PosW:0]   w_trial;
    logic [PosW:0]   w_sub;
    logic [7:0]      w_c;

    assign w_a     = r_clo[r_ch*8 +: 8];
    assign w_b     = r_chi[r_ch*8 +: 8];
    assign w_pa    = w_a * r_whi;
    assign w_pb    = w_b * r_wlo;
    assign w_trial = {r_rem[PosW-1:0], r_num[NumW-1]};
    assign w_sub   = w_trial - {1'b0, r_d};
    assign w_c     = (r_quo > NumW'(255)) ? 8'hFF : r_quo[7:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_ch    <= 2'd0;
                r_phase <= 2'd0;
                r_d     <= i_scan.hi - i_scan.lo;
                r_whi   <= i_scan.hi - i_v;
                r_wlo   <= i_v - i_scan.lo;
                r_clo   <= i_scan.lo_col;
                r_chi   <= i_scan.hi_col;
            end else if (r_busy) begin
                unique case (r_phase)
                    2'd0: begin
                        r_num   <= NumW'(w_pa) + NumW'(r_d >> 1);
                        r_phase <= 2'd1;
                    end
                    2'd1: begin
                        r_num   <= r_num + NumW'(w_pb);
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_bit   <= 5'(NumW - 1);
                        r_phase <= 2'd2;
                    end
                    2'd2: begin
                        r_num <= {r_num[NumW-2:0], 1'b0};
                        if (!w_sub[PosW]) begin
                            r_rem <= w_sub;
                            r_quo <= {r_quo[NumW-2:0], 1'b1};
                        end else begin
                            r_rem <= w_trial;
                            r_quo <= {r_quo[NumW-2:0], 1'b0};
                        end
                        if (r_bit == 5'd0) begin
                            r_phase <= 2'd3;
                        end else begin
                            r_bit <= r_bit - 5'd1;
                        end
                    end
                    default: begin
                        r_out[r_ch*8 +: 8] <= w_c;
                        r_phase <= 2'd0;
                        r_ch    <= r_ch + 2'd1;
                        if (r_ch == 2'd3) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    assign o_done  = r_done;
    assign o_color = r_out;
endmodule

// File: sv/piecewise_color_ramp_lookup.sv
// ----------------------------------------------------------------------------
// piecewise_color_ramp_lookup: piecewise linear colour ramp
// A row of control-point cells scanned one cell a cycle, then a serial blend.
// ----------------------------------------------------------------------------
// Sequence: a write result is valid in the cycle after acceptance; a query
//   runs the cell scan; in step mode, on an exact hit or with a neighbour
//   missing it returns a stored colour, else a start step, four channels of
//   two multiply steps, a 25-bit division and a store each, and a done step.
// Throughput: one transaction at a time; the next is taken in the cycle after
//   the result leaves, so the scan chain and the divider set the rate.
// Reset: synchronous, active low; loads the default rainbow table, mode linear,
//   count 7.
module piecewise_color_ramp_lookup
    import pcrl_pkg::*;
#(
    parameter int MAX_POINTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB-style configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: opcode[0], entry_index[4:1], value[20:5], color_in[52:21], zeros
    input  logic [55:0] s_axis_tdata,
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: color_out[31:0], status[32], zeros
    output logic [39:0] m_axis_tdata
);
    localparam int CntW = $clog2(MAX_POINTS + 1);
    localparam int StW  = $clog2(MAX_POINTS + 2);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_BLND = 2'd2;

    // Configuration registers.
    logic       r_mode;
    logic [4:0] r_count;
    logic       w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_count <= 5'd7;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_MODE[0]:  r_mode  <= pwdata[0];
                REG_COUNT[0]: r_count <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MODE[0]:  prdata = {31'd0, r_mode};
            REG_COUNT[0]: prdata = {27'd0, r_count};
            default:      prdata = '0;
        endcase
    end

    // Count in use, clamped to 2..MAX_POINTS.
    logic [CntW-1:0] w_n;
    always_comb begin
        if (r_count < 5'd2)                       w_n = CntW'(2);
        else if (32'(r_count) > MAX_POINTS)        w_n = CntW'(MAX_POINTS);
        else                                       w_n = CntW'(r_count);
    end

    // Input field unpacking.
    logic            w_op;
    logic [3:0]      w_idx;
    logic [PosW-1:0] w_val;
    logic [ColW-1:0] w_col;
    assign w_op  = s_axis_tdata[0];
    assign w_idx = s_axis_tdata[4:1];
    assign w_val = s_axis_tdata[20:5];
    assign w_col = s_axis_tdata[52:21];

    logic [1:0]      r_state;
    logic [StW-1:0]  r_step;
    logic [PosW-1:0] r_v;
    logic            r_ovalid;
    logic [ColW-1:0] r_ocol;
    logic            r_ostat;
    logic            w_acc;
    logic            w_wr_ok;
    logic [PosW-1:0] w_wpos;

    assign s_axis_tready = (r_state == ST_IDLE) && !r_ovalid;
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_wr_ok       = (w_op == OP_WRITE) && (CntW'(w_idx) < w_n)
                           && (32'(w_idx) < MAX_POINTS);
    assign w_wpos = (w_idx == 4'd0) ? 16'd0 : (w_idx == 4'd1) ? 16'd65535 : w_val;

    // Cell chain: cell k folds in its entry on the step k of the scan.
    t_scan w_chain [MAX_POINTS+1];
    t_scan w_last;
    logic  w_step;
    assign w_step     = (r_state == ST_SCAN);
    assign w_chain[0] = '0;

    genvar k;
    generate
        for (k = 0; k < MAX_POINTS; k++) begin : g_cell
            pcrl_cell #(.IDX(k)) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_we     (w_acc && w_wr_ok && (32'(w_idx) == k)),
                .i_wpos   (w_wpos),
                .i_wcol   (w_col),
                .i_step   (w_step && (32'(r_step) == k)),
                .i_active (CntW'(k) < w_n),
                .i_v      (r_v),
                .i_scan   (w_chain[k]),
                .o_scan   (w_chain[k+1])
            );
        end
    endgenerate
    assign w_last = w_chain[MAX_POINTS];

    logic            w_bdone;
    logic [ColW-1:0] w_bcol;
    logic            w_bstart;
    logic            w_plain;

    // Exact hit, step mode or a missing neighbour: no blend; the lower colour stands, else the upper.
    assign w_plain  = !w_last.have_lo || (w_last.lo == r_v) || r_mode
                      || !w_last.have_hi;
    assign w_bstart = (r_state == ST_SCAN) && (32'(r_step) == MAX_POINTS) && !w_plain;

    pcrl_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_bstart),
        .i_scan  (w_last),
        .i_v     (r_v),
        .o_done  (w_bdone),
        .o_color (w_bcol)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_acc) begin
                        r_v    <= w_val;
                        r_step <= '0;
                        if (w_op == OP_WRITE) begin
                            r_ovalid <= 1'b1;
                            r_ocol   <= '0;
                            r_ostat  <= !w_wr_ok;
                        end else begin
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (32'(r_step) == MAX_POINTS) begin
                        if (w_plain) begin
                            r_ovalid <= 1'b1;
                            r_ostat  <= 1'b0;
                            r_ocol   <= w_last.have_lo ? w_last.lo_col :
                                        (w_last.have_hi ? w_last.hi_col : '0);
                            r_state  <= ST_IDLE;
                        end else begin
                            r_state <= ST_BLND;
                        end
                    end else begin
                        r_step <= r_step + StW'(1);
                    end
                end
                ST_BLND: begin
                    if (w_bdone) begin
                        r_ovalid <= 1'b1;
                        r_ostat  <= 1'b0;
                        r_ocol   <= w_bcol;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'd0, r_ostat, r_ocol};
endmodule

// File: sv/pcrl_checker.sv
// ----------------------------------------------------------------------------
// pcrl_checker: port-level checks for the colour ramp lookup
// Watches the stream and configuration ports over time.
// ----------------------------------------------------------------------------
module pcrl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        pready,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [55:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);
    // One transaction in flight: no new input while a result waits.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while result pending");

    // A write produces a zero colour result on the next cycle.
    a_write_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tdata[0])
        |=> (m_axis_tvalid && m_axis_tdata[31:0] == 32'd0))
        else $error("write result missing or non-zero");

    // A query result never appears on the cycle after acceptance.
    a_query_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && !s_axis_tdata[0])
        |=> !m_axis_tvalid)
        else $error("query result too early");

    a_cfg_ready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
endmodule

bind piecewise_color_ramp_lookup pcrl_checker u_pcrl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
